/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check, masked while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ezr_pkg.sv */
package ezr_pkg;

	localparam int TRIG_ITERATIONS_DEF = 16;
	localparam int TABLE_LEN = 24;

	localparam int AW = 16;  // angle, Q3.13
	localparam int ZW = 28;  // CORDIC datapath, Q.24
	localparam int TW = 22;  // trig values, Q.20
	localparam int PW = 44;  // two-factor product, Q.40
	localparam int VW = 68;  // full element before rounding, Q.60
	localparam int OW = 16;  // output, Q1.14

	localparam logic signed [AW-1:0] ANG_PI      = 16'sd25736;
	localparam logic signed [AW-1:0] ANG_HALF_PI = 16'sd12868;
	localparam logic signed [ZW-1:0] CORDIC_KINV = 28'sd10188014;
	localparam logic signed [VW-1:0] OUT_MAX     = 68'sd16384;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		case (idx)
			5'd0:    r = 28'sd13176795;
			5'd1:    r = 28'sd7778716;
			5'd2:    r = 28'sd4110060;
			5'd3:    r = 28'sd2086331;
			5'd4:    r = 28'sd1047214;
			5'd5:    r = 28'sd524117;
			5'd6:    r = 28'sd262123;
			5'd7:    r = 28'sd131069;
			5'd8:    r = 28'sd65536;
			5'd9:    r = 28'sd32768;
			5'd10:   r = 28'sd16384;
			5'd11:   r = 28'sd8192;
			5'd12:   r = 28'sd4096;
			5'd13:   r = 28'sd2048;
			5'd14:   r = 28'sd1024;
			5'd15:   r = 28'sd512;
			5'd16:   r = 28'sd256;
			5'd17:   r = 28'sd128;
			5'd18:   r = 28'sd64;
			5'd19:   r = 28'sd32;
			5'd20:   r = 28'sd16;
			5'd21:   r = 28'sd8;
			5'd22:   r = 28'sd4;
			5'd23:   r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/ezr_cordic.sv */
module ezr_cordic
	import ezr_pkg::*;
#(
	parameter int N = TRIG_ITERATIONS_DEF
) (
	input  logic                 clk,
	input  logic [N+1:0]         en,
	input  logic signed [AW-1:0] angle,
	output logic signed [TW-1:0] cos_v,
	output logic signed [TW-1:0] sin_v
);

	logic signed [AW-1:0] a_c;
	logic signed [AW-1:0] a_f;
	logic                 neg_f;
	logic signed [ZW-1:0] z0_s;
	logic                 neg0_s;
	logic signed [ZW-1:0] x_s [1:N];
	logic signed [ZW-1:0] y_s [1:N];
	logic signed [ZW-1:0] z_s [1:N];
	logic                 neg_s [1:N];
	logic signed [ZW-1:0] xn;
	logic signed [ZW-1:0] yn;

	// saturate to a half turn, then fold into the right half plane
	always_comb begin
		a_c = angle;
		if (angle > ANG_PI)
			a_c = ANG_PI;
		else if (angle < -ANG_PI)
			a_c = -ANG_PI;
		a_f = a_c;
		neg_f = 1'b0;
		if (a_c > ANG_HALF_PI) begin
			a_f = a_c - ANG_PI;
			neg_f = 1'b1;
		end else if (a_c < -ANG_HALF_PI) begin
			a_f = a_c + ANG_PI;
			neg_f = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z0_s <= ZW'(a_f) <<< 11;
			neg0_s <= neg_f;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [ZW-1:0] xi, yi, zi;
		logic ni;
		if (i == 0) begin : g_first
			assign xi = CORDIC_KINV;
			assign yi = '0;
			assign zi = z0_s;
			assign ni = neg0_s;
		end else begin : g_next
			assign xi = x_s[i];
			assign yi = y_s[i];
			assign zi = z_s[i];
			assign ni = neg_s[i];
		end
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				if (!zi[ZW-1]) begin
					x_s[i+1] <= xi - (yi >>> i);
					y_s[i+1] <= yi + (xi >>> i);
					z_s[i+1] <= zi - atan_q24(5'(i));
				end else begin
					x_s[i+1] <= xi + (yi >>> i);
					y_s[i+1] <= yi - (xi >>> i);
					z_s[i+1] <= zi + atan_q24(5'(i));
				end
				neg_s[i+1] <= ni;
			end
		end
	end

	assign xn = neg_s[N] ? -x_s[N] : x_s[N];
	assign yn = neg_s[N] ? -y_s[N] : y_s[N];

	// round Q.24 to Q.20, half up
	always_ff @(posedge clk) begin
		if (en[N+1]) begin
			cos_v <= TW'((xn + ZW'(8)) >>> 4);
			sin_v <= TW'((yn + ZW'(8)) >>> 4);
		end
	end

endmodule

/* rtl/core/euler_zyx_rotation_matrix.sv */
// channel | direction | valid / stall          | fields
// input   | in        | in_valid / in_stall    | angle_x angle_y angle_z
// output  | out       | out_valid / out_stall  | r00 r01 r02 r10 r11 r12 r20 r21 r22
//
// One beat per cycle while out_stall is low. Stages in order: angle fold, one
// stage per CORDIC micro-rotation, trig rounding, then four product stages.
// Each stage holds its own valid bit and advances when the next one is empty or
// moving, so bubbles fill up while the output is stalled.
// in_stall rises only when every stage holds a beat and out_stall is high.
// Reset clears the valid bits only.
`include "assert_macros.svh"

module euler_zyx_rotation_matrix
	import ezr_pkg::*;
#(
	parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [AW-1:0] angle_x,
	input  logic signed [AW-1:0] angle_y,
	input  logic signed [AW-1:0] angle_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [OW-1:0] r00,
	output logic signed [OW-1:0] r01,
	output logic signed [OW-1:0] r02,
	output logic signed [OW-1:0] r10,
	output logic signed [OW-1:0] r11,
	output logic signed [OW-1:0] r12,
	output logic signed [OW-1:0] r20,
	output logic signed [OW-1:0] r21,
	output logic signed [OW-1:0] r22
);

	localparam int N = (TRIG_ITERATIONS > TABLE_LEN) ? TABLE_LEN : TRIG_ITERATIONS;
	localparam int L = N + 6;
	localparam int P1 = N + 2;

	logic [L-1:0] vld_q;
	logic [L:0]   rdy;
	logic [L-1:0] en;

	logic signed [TW-1:0] cx, sx, cy, sy, cz, sz;

	logic signed [PW-1:0] pr_s1 [10];
	logic signed [TW-1:0] sx_s1, cx_s1, sy_s1;
	logic signed [PW-1:0] pr_s2 [10];
	logic signed [PW-1:0] hp_s2 [4];
	logic signed [PW:0]   lp_s2 [4];
	logic signed [TW-1:0] sy_s2;
	logic signed [VW-1:0] a_s3 [9];
	logic signed [VW-1:0] b_s3 [9];
	logic signed [OW-1:0] r_s4 [9];

	logic signed [TW-1:0] hi [4];
	logic signed [TW:0]   lo [4];
	logic signed [TW-1:0] sel [4];
	logic signed [VW-1:0] full [4];

	// ready ripples back from the output; a stage moves when its successor can take it
	always_comb begin
		rdy[L] = !out_stall;
		for (int k = L - 1; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
		en = rdy[L-1:0];
	end

	assign in_stall = !rdy[0];
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < L; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	ezr_cordic #(.N(N)) u_trig_x (
		.clk(clk), .en(en[N+1:0]), .angle(angle_x), .cos_v(cx), .sin_v(sx)
	);
	ezr_cordic #(.N(N)) u_trig_y (
		.clk(clk), .en(en[N+1:0]), .angle(angle_y), .cos_v(cy), .sin_v(sy)
	);
	ezr_cordic #(.N(N)) u_trig_z (
		.clk(clk), .en(en[N+1:0]), .angle(angle_z), .cos_v(cz), .sin_v(sz)
	);

	// two-factor products, Q.40
	always_ff @(posedge clk) begin
		if (en[P1]) begin
			pr_s1[0] <= PW'(cz) * PW'(cy);
			pr_s1[1] <= PW'(sz) * PW'(cy);
			pr_s1[2] <= PW'(cy) * PW'(cx);
			pr_s1[3] <= PW'(cy) * PW'(sx);
			pr_s1[4] <= PW'(cz) * PW'(sy);
			pr_s1[5] <= PW'(sz) * PW'(sy);
			pr_s1[6] <= PW'(cz) * PW'(cx);
			pr_s1[7] <= PW'(sz) * PW'(cx);
			pr_s1[8] <= PW'(cz) * PW'(sx);
			pr_s1[9] <= PW'(sz) * PW'(sx);
			sx_s1 <= sx;
			cx_s1 <= cx;
			sy_s1 <= sy;
		end
	end

	// split the Q.40 factor so each third-factor product stays narrow
	always_comb begin
		hi[0] = signed'(pr_s1[4][PW-1:TW]);
		hi[1] = hi[0];
		hi[2] = signed'(pr_s1[5][PW-1:TW]);
		hi[3] = hi[2];
		lo[0] = signed'({1'b0, pr_s1[4][TW-1:0]});
		lo[1] = lo[0];
		lo[2] = signed'({1'b0, pr_s1[5][TW-1:0]});
		lo[3] = lo[2];
		sel[0] = sx_s1;
		sel[1] = cx_s1;
		sel[2] = sx_s1;
		sel[3] = cx_s1;
	end

	always_ff @(posedge clk) begin
		if (en[P1+1]) begin
			for (int j = 0; j < 4; j++) begin
				hp_s2[j] <= PW'(hi[j]) * PW'(sel[j]);
				lp_s2[j] <= (PW+1)'(lo[j]) * (PW+1)'(sel[j]);
			end
			for (int j = 0; j < 10; j++)
				pr_s2[j] <= pr_s1[j];
			sy_s2 <= sy_s1;
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++)
			full[j] = (VW'(hp_s2[j]) <<< TW) + VW'(lp_s2[j]);
	end

	// line up both addends of each element in Q.60
	always_ff @(posedge clk) begin
		if (en[P1+2]) begin
			a_s3[0] <= VW'(pr_s2[0]) <<< 20;
			b_s3[0] <= '0;
			a_s3[1] <= full[0];
			b_s3[1] <= -(VW'(pr_s2[7]) <<< 20);
			a_s3[2] <= full[1];
			b_s3[2] <= VW'(pr_s2[9]) <<< 20;
			a_s3[3] <= VW'(pr_s2[1]) <<< 20;
			b_s3[3] <= '0;
			a_s3[4] <= full[2];
			b_s3[4] <= VW'(pr_s2[6]) <<< 20;
			a_s3[5] <= full[3];
			b_s3[5] <= -(VW'(pr_s2[8]) <<< 20);
			a_s3[6] <= -(VW'(sy_s2) <<< 40);
			b_s3[6] <= '0;
			a_s3[7] <= VW'(pr_s2[3]) <<< 20;
			b_s3[7] <= '0;
			a_s3[8] <= VW'(pr_s2[2]) <<< 20;
			b_s3[8] <= '0;
		end
	end

	// round half up to Q1.14 and clip
	always_ff @(posedge clk) begin
		logic signed [VW-1:0] q;
		if (en[P1+3]) begin
			for (int j = 0; j < 9; j++) begin
				q = (a_s3[j] + b_s3[j] + (VW'(1) <<< 45)) >>> 46;
				if (q > OUT_MAX)
					r_s4[j] <= OW'(OUT_MAX);
				else if (q < -OUT_MAX)
					r_s4[j] <= OW'(-OUT_MAX);
				else
					r_s4[j] <= OW'(q);
			end
		end
	end

	assign r00 = r_s4[0];
	assign r01 = r_s4[1];
	assign r02 = r_s4[2];
	assign r10 = r_s4[3];
	assign r11 = r_s4[4];
	assign r12 = r_s4[5];
	assign r20 = r_s4[6];
	assign r21 = r_s4[7];
	assign r22 = r_s4[8];

	`ASSERT_IMP(a_full_when_stalled, clk, arst_n, in_stall, (&vld_q) && out_stall, "input stalled with a free stage")
	`ASSERT_IMP(a_flow_when_open, clk, arst_n, !out_stall, &en, "pipeline held without output stall")
	`ASSERT_IMP(a_out_range, clk, arst_n, out_valid, (r00 <= 16'sd16384) && (r00 >= -16'sd16384) && (r22 <= 16'sd16384) && (r22 >= -16'sd16384), "element beyond unit range")
	`ASSERT_CLK(a_advance_on_take, clk, arst_n, !$past(out_valid && !out_stall && !vld_q[L-2]) || !out_valid, "beat repeated at output")

endmodule

/* tb/sv/tb.sv */
module tb;
	import ezr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITERS = TRIG_ITERATIONS_DEF;
	localparam int LATENCY = ITERS + 6;
	localparam int RANDOM_ITEMS = 1850;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [15:0] m [9];
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [AW-1:0] angle_x = '0, angle_y = '0, angle_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	matrix_t expected_matrices [$];
	int errors = 0;
	int checked = 0;
	longint cycles = 0;
	bit hold_output = 1'b0;
	bit allow_output_gaps = 1'b1;

	euler_zyx_rotation_matrix dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_entry(int i);
		longint tbl [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return tbl[i];
	endfunction

	// cos and sin in Q.20 from a Q3.13 angle
	task automatic cordic_trig(input longint a, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		x = 10188014;
		y = 0;
		flip = 0;
		if (a > 25736) a = 25736;
		if (a < -25736) a = -25736;
		if (a > 12868) begin
			a -= 25736;
			flip = 1;
		end else if (a < -12868) begin
			a += 25736;
			flip = 1;
		end
		z = a * 2048;
		for (int i = 0; i < ITERS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= atan_entry(i);
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += atan_entry(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = floor_shift(x + 8, 4);
		s = floor_shift(y + 8, 4);
	endtask

	function automatic logic signed [15:0] round_element(longint v);
		longint r;
		r = floor_shift(v + (64'sd1 <<< 45), 46);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r[15:0];
	endfunction

	task automatic predict_matrix(input logic signed [15:0] ax, ay, az, output matrix_t mt);
		longint cx, sx, cy, sy, cz, sz, czsy, szsy;
		longint k20, k40;
		k20 = 64'sd1 <<< 20;
		k40 = 64'sd1 <<< 40;
		cordic_trig(ax, cx, sx);
		cordic_trig(ay, cy, sy);
		cordic_trig(az, cz, sz);
		czsy = cz * sy;
		szsy = sz * sy;
		mt.m[0] = round_element(cz * cy * k20);
		mt.m[1] = round_element(czsy * sx - sz * cx * k20);
		mt.m[2] = round_element(czsy * cx + sz * sx * k20);
		mt.m[3] = round_element(sz * cy * k20);
		mt.m[4] = round_element(szsy * sx + cz * cx * k20);
		mt.m[5] = round_element(szsy * cx - cz * sx * k20);
		mt.m[6] = round_element(-sy * k40);
		mt.m[7] = round_element(cy * sx * k20);
		mt.m[8] = round_element(cy * cx * k20);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Offer one beat; gaps go before it, valid stays high across back-to-back beats.
	task automatic send_angles(input logic signed [15:0] ax, ay, az, input bit gaps = 1);
		matrix_t mt;
		int g;
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		predict_matrix(ax, ay, az, mt);
		expected_matrices.push_back(mt);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	// Receiver stall pattern
	always @(posedge clk) begin
		if (hold_output) begin
			out_stall <= 1'b1;
		end else if (allow_output_gaps && $urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		matrix_t mt;
		logic signed [15:0] got [9];
		string names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
		if (arst_n && out_valid && !out_stall) begin
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (expected_matrices.size() == 0) begin
				$error("matrix beat with nothing expected");
				errors++;
			end else begin
				mt = expected_matrices.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== mt.m[i]) begin
						$error("%s: expected %0d, got %0d", names[i], mt.m[i], got[i]);
						errors++;
					end
				checked++;
			end
		end
	end

	task automatic test_extremes();
		logic signed [15:0] corners [13] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
			-16'sd12868, 16'sd12869, -16'sd12869, 16'sd32767, -16'sd32768, 16'sd25737,
			-16'sd25737, 16'sd1, -16'sd1};
		foreach (corners[i])
			send_angles(corners[i], corners[(i + 3) % 13], corners[(i + 7) % 13]);
		send_angles(16'sd6434, 16'sd12868, -16'sd6434);
		send_angles(16'sd32767, 16'sd32767, 16'sd32767);
		send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
		send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
		send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
		stop_sending();
	endtask

	function automatic logic signed [15:0] rand_angle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return 16'($urandom_range(0, 51472) - 25736);
		if (r < 95) return 16'($urandom());
		return 16'(($urandom_range(0, 1) ? 16'sd12868 : 16'sd25736)
			* ($urandom_range(0, 1) ? 1 : -1) + $signed($urandom_range(0, 4)) - 2);
	endfunction

	task automatic test_random_poses();
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_angles(rand_angle(), rand_angle(), rand_angle(), (i % 300) < 200);
		stop_sending();
	endtask

	// Hold the output long enough that the pipe fills and pushes back on input.
	task automatic test_backpressure();
		hold_output = 1'b1;
		fork
			begin
				repeat (3 * LATENCY + 20) @(posedge clk);
				hold_output = 1'b0;
			end
			for (int i = 0; i < 3 * LATENCY; i++)
				send_angles(rand_angle(), rand_angle(), rand_angle(), 0);
		join
		stop_sending();
	endtask

	task automatic drain();
		while (expected_matrices.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_backpressure();
		test_random_poses();
		drain();
		$display("Checked %0d rotation matrices: angle corners, folds, saturation,", checked);
		$display("random poses with gaps on both sides and a filled pipeline.");
		if (errors == 0 && expected_matrices.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
